FILE: hw/rtl/stuffed_frame_encoder_assert.svh
// assertion macros shared by the stuffed frame encoder modules
// no dependencies; define ASSERT_OFF to compile the checks out
`ifndef STUFFED_FRAME_ENCODER_ASSERT_SVH
`define STUFFED_FRAME_ENCODER_ASSERT_SVH

`ifndef ASSERT_OFF

// check held at every clock edge outside reset
`define SFE_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("stuffed frame encoder check failed");

// check held at every clock edge, reset included
`define SFE_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) (prop)) \
      else $error("stuffed frame encoder check failed");

`else

`define SFE_ASSERT(label, clk, rst, prop)
`define SFE_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

FILE: hw/rtl/sfe_pkg.sv
// types and constants of the stuffed frame encoder
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package sfe_pkg;

   // register indexes of the configuration port
   localparam int unsigned CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_ESCAPE_ENABLE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FLAG_BYTE     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ESCAPE_PREFIX = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PREFIX_CODE   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FLAG_CODE     = 3'd4;

   // reset values of the configuration registers
   localparam logic       RST_ESCAPE_ENABLE = 1'b1;
   localparam logic [7:0] RST_FLAG_BYTE     = 8'hAA;
   localparam logic [7:0] RST_ESCAPE_PREFIX = 8'hBB;
   localparam logic [7:0] RST_PREFIX_CODE   = 8'h0B;
   localparam logic [7:0] RST_FLAG_CODE     = 8'h0A;

   // length field counts the payload plus four length bytes and the command
   localparam int unsigned COUNT_W      = 16;
   localparam int unsigned LEN_W        = COUNT_W + 1;
   localparam int unsigned HEADER_EXTRA = 5;

   // queue between front and back, depth a power of two
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic       escape_enable;
      logic [7:0] flag_byte;
      logic [7:0] escape_prefix;
      logic [7:0] prefix_code;
      logic [7:0] flag_code;
   } cfg_type;

   // one classified payload byte with everything the back end needs
   typedef struct packed {
      logic [7:0]       data;
      logic [7:0]       cmd;
      logic [LEN_W-1:0] len;
      logic             first;
      logic             last;
      logic [7:0]       csum;
   } job_type;

endpackage

FILE: hw/rtl/sfe_front.sv
// front end: takes payload bytes, tracks the open frame and running sum
// depends on sfe_pkg and stuffed_frame_encoder_assert.svh
`timescale 1ns / 1ps
`include "stuffed_frame_encoder_assert.svh"

module sfe_front #(
   parameter int unsigned MAX_PAYLOAD = 65535
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [7:0]                  payload_byte,
   input  logic                        first_byte,
   input  logic                        last_byte,
   input  logic [7:0]                  command,
   input  logic [sfe_pkg::COUNT_W-1:0] payload_count,
   input  logic                        q_ready,
   output logic                        push,
   output sfe_pkg::job_type            job
);

   logic                        frame_open_ff, frame_open_in;
   logic [7:0]                  running_sum_ff, running_sum_in;
   logic                        accept;
   logic [sfe_pkg::COUNT_W-1:0] count_sat;
   logic [sfe_pkg::LEN_W-1:0]   len;
   logic [7:0]                  header_sum;
   logic [7:0]                  csum;

   assign req_tready = q_ready;
   assign accept     = req_tvalid && req_tready;

   // bytes outside an open frame are dropped here
   assign push = accept && (first_byte || frame_open_ff);

   // length field and the sum of the header bytes
   assign count_sat = (payload_count > sfe_pkg::COUNT_W'(MAX_PAYLOAD)) ?
                      sfe_pkg::COUNT_W'(MAX_PAYLOAD) : payload_count;
   assign len = sfe_pkg::LEN_W'(count_sat) + sfe_pkg::LEN_W'(sfe_pkg::HEADER_EXTRA);
   assign header_sum = {7'd0, len[16]} + len[15:8] + len[7:0] + command;

   // running sum including this byte
   assign csum = (first_byte ? header_sum : running_sum_ff) + payload_byte;

   assign job.data  = payload_byte;
   assign job.cmd   = command;
   assign job.len   = len;
   assign job.first = first_byte;
   assign job.last  = last_byte;
   assign job.csum  = csum;

   // frame state update on every byte that goes on
   always_comb begin
      frame_open_in  = frame_open_ff;
      running_sum_in = running_sum_ff;
      if (push) begin
         frame_open_in  = !last_byte;
         running_sum_in = last_byte ? 8'd0 : csum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_open_ff  <= 1'b0;
         running_sum_ff <= 8'd0;
      end else begin
         frame_open_ff  <= frame_open_in;
         running_sum_ff <= running_sum_in;
      end
   end

   // a dropped byte leaves the running sum alone
   `SFE_ASSERT(a_drop_keeps_sum, clock, reset,
      accept && !first_byte && !frame_open_ff |=> $stable(running_sum_ff))
   // a closing byte ends the frame and clears the sum
   `SFE_ASSERT(a_last_closes, clock, reset,
      push && last_byte |=> !frame_open_ff && running_sum_ff == 8'd0)
   // a byte is only passed on into free queue space
   `SFE_ASSERT(a_push_has_room, clock, reset, push |-> q_ready)

endmodule

FILE: hw/rtl/sfe_queue.sv
// short queue of classified bytes between front and back end
// depends on sfe_pkg and stuffed_frame_encoder_assert.svh
`timescale 1ns / 1ps
`include "stuffed_frame_encoder_assert.svh"

module sfe_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  sfe_pkg::job_type push_job,
   output logic             q_ready,
   input  logic             pop,
   output logic             head_valid,
   output sfe_pkg::job_type head
);

   sfe_pkg::job_type              slot_ff [sfe_pkg::QUEUE_DEPTH];
   logic [sfe_pkg::QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [sfe_pkg::QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [sfe_pkg::QCNT_W-1:0]    count_ff, count_in;

   assign q_ready    = count_ff != sfe_pkg::QCNT_W'(sfe_pkg::QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head       = slot_ff[rd_ptr_ff];

   // pointers wrap on their own since the depth is a power of two
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // slot storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   `SFE_ASSERT(a_pop_not_empty, clock, reset, pop |-> count_ff != '0)
   `SFE_ASSERT(a_push_grows, clock, reset,
      push && !pop |=> count_ff == $past(count_ff) + 1'b1)
   `SFE_ASSERT(a_ptr_gap, clock, reset,
      count_ff == '0 || count_ff == sfe_pkg::QCNT_W'(sfe_pkg::QUEUE_DEPTH) ||
      wr_ptr_ff != rd_ptr_ff)

endmodule

FILE: hw/rtl/sfe_back.sv
// back end: sequences header, stuffed payload, checksum and closing flag
// depends on sfe_pkg and stuffed_frame_encoder_assert.svh
`timescale 1ns / 1ps
`include "stuffed_frame_encoder_assert.svh"

module sfe_back (
   input  logic             clock,
   input  logic             reset,
   input  sfe_pkg::cfg_type cfg,
   input  logic             head_valid,
   input  sfe_pkg::job_type head,
   output logic             pop,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [7:0]       rsp_tdata,
   output logic             rsp_tlast
);

   // byte position within the bytes of one queued entry
   localparam logic [3:0] PH_HFLAG    = 4'd0;
   localparam logic [3:0] PH_LEN3     = 4'd1;
   localparam logic [3:0] PH_LEN2     = 4'd2;
   localparam logic [3:0] PH_LEN1     = 4'd3;
   localparam logic [3:0] PH_LEN0     = 4'd4;
   localparam logic [3:0] PH_CMD      = 4'd5;
   localparam logic [3:0] PH_DATA     = 4'd6;
   localparam logic [3:0] PH_DATA_ESC = 4'd7;
   localparam logic [3:0] PH_SUM      = 4'd8;
   localparam logic [3:0] PH_SUM_ESC  = 4'd9;
   localparam logic [3:0] PH_EFLAG    = 4'd10;

   logic       busy_ff, busy_in;
   logic [3:0] phase_ff, phase_in;
   logic [3:0] phase_cur, phase_next;
   logic       rsp_tvalid_ff, rsp_tvalid_in;
   logic [7:0] rsp_tdata_ff;
   logic       rsp_tlast_ff;
   logic       load;
   logic       done;
   logic [7:0] byte_out;
   logic       end_out;
   logic       data_is_prefix, data_esc;
   logic       sum_is_prefix, sum_esc;

   // escape decisions, the prefix rule wins over the flag rule
   assign data_is_prefix = head.data == cfg.escape_prefix;
   assign data_esc = cfg.escape_enable && (data_is_prefix || head.data == cfg.flag_byte);
   assign sum_is_prefix = head.csum == cfg.escape_prefix;
   assign sum_esc = cfg.escape_enable && (sum_is_prefix || head.csum == cfg.flag_byte);

   // a fresh entry starts at its header or straight at its payload byte
   assign phase_cur = busy_ff ? phase_ff : (head.first ? PH_HFLAG : PH_DATA);

   // output register takes a byte when empty or being drained
   assign load = head_valid && (!rsp_tvalid_ff || rsp_tready);
   assign pop  = load && done;

   // byte selection and next position
   always_comb begin
      byte_out   = cfg.flag_byte;
      end_out    = 1'b0;
      done       = 1'b0;
      phase_next = PH_DATA;
      case (phase_cur)
         PH_HFLAG: begin
            phase_next = PH_LEN3;
         end
         PH_LEN3: begin
            byte_out   = 8'd0;
            phase_next = PH_LEN2;
         end
         PH_LEN2: begin
            byte_out   = {7'd0, head.len[16]};
            phase_next = PH_LEN1;
         end
         PH_LEN1: begin
            byte_out   = head.len[15:8];
            phase_next = PH_LEN0;
         end
         PH_LEN0: begin
            byte_out   = head.len[7:0];
            phase_next = PH_CMD;
         end
         PH_CMD: begin
            byte_out   = head.cmd;
            phase_next = PH_DATA;
         end
         PH_DATA: begin
            if (data_esc) begin
               byte_out   = cfg.escape_prefix;
               phase_next = PH_DATA_ESC;
            end else begin
               byte_out   = head.data;
               done       = !head.last;
               phase_next = PH_SUM;
            end
         end
         PH_DATA_ESC: begin
            byte_out   = data_is_prefix ? cfg.prefix_code : cfg.flag_code;
            done       = !head.last;
            phase_next = PH_SUM;
         end
         PH_SUM: begin
            if (sum_esc) begin
               byte_out   = cfg.escape_prefix;
               phase_next = PH_SUM_ESC;
            end else begin
               byte_out   = head.csum;
               phase_next = PH_EFLAG;
            end
         end
         PH_SUM_ESC: begin
            byte_out   = sum_is_prefix ? cfg.prefix_code : cfg.flag_code;
            phase_next = PH_EFLAG;
         end
         PH_EFLAG: begin
            end_out = 1'b1;
            done    = 1'b1;
         end
         default: begin
            done = 1'b1;
         end
      endcase
   end

   // sequencer state
   always_comb begin
      busy_in  = busy_ff;
      phase_in = phase_ff;
      if (load) begin
         busy_in  = !done;
         phase_in = phase_next;
      end
      rsp_tvalid_in = rsp_tvalid_ff;
      if (load) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         phase_ff      <= PH_HFLAG;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         busy_ff       <= busy_in;
         phase_ff      <= phase_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   // output payload register
   always_ff @(posedge clock) begin
      if (load) begin
         rsp_tdata_ff <= byte_out;
         rsp_tlast_ff <= end_out;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tlast  = rsp_tlast_ff;

   `SFE_ASSERT(a_end_is_flag, clock, reset,
      rsp_tvalid_ff && rsp_tlast_ff |-> rsp_tdata_ff == cfg.flag_byte)
   `SFE_ASSERT(a_pop_has_head, clock, reset, pop |-> head_valid)
   `SFE_ASSERT(a_flag_ends_entry, clock, reset,
      load && phase_cur == PH_EFLAG |=> !busy_ff)

endmodule

FILE: hw/rtl/stuffed_frame_encoder.sv
// stuffed frame encoder, top level: configuration registers and the three parts
// depends on sfe_pkg, sfe_front, sfe_queue, sfe_back
//
// Payload bytes enter on the req_ stream, one per transfer; req_tuser marks the
// first byte of a frame, req_tlast the last. With the first byte the block sends
// the flag byte, a 4-byte big-endian length (count plus 5) and the command byte.
// Payload bytes and the closing 8-bit additive checksum are byte-stuffed when
// escaping is on, and the closing flag goes out with rsp_tlast high. Bytes that
// arrive while no frame is open are dropped. The csr_ port writes the five
// registers (csr_ready is always high); write them only while no byte is in flight.
// Each item gives 0 to 11 output bytes; the output register sends one byte per
// cycle unless rsp_ stalls. A plain payload byte gives one, a stuffed one two, the
// first byte of a frame seven or eight, and a last byte two or three more for the
// checksum and closing flag. When the block is empty, an item's first byte passes
// the queue and then the output register before rsp_tvalid rises. A two-entry queue
// lets req_ keep moving while rsp_ is stalled; when it fills, req_tready drops.
// Reset restores the default registers, empties the queue, closes any open frame.
`timescale 1ns / 1ps

module stuffed_frame_encoder #(
   parameter int unsigned MAX_PAYLOAD = 65535
) (
   input  logic                          clock,
   input  logic                          reset,
   // payload in
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [31:0]                   req_tdata,  // payload_byte, command, payload_count
   input  logic                          req_tuser,  // first_byte
   input  logic                          req_tlast,  // last_byte
   // encoded frame out
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [7:0]                    rsp_tdata,  // out_byte
   output logic                          rsp_tlast,  // frame_end
   // register writes
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [sfe_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]                    csr_data
);

   sfe_pkg::cfg_type cfg_ff, cfg_in;
   sfe_pkg::job_type push_job, head;
   logic             push, pop, q_ready, head_valid;

   // configuration registers
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            sfe_pkg::CSR_ESCAPE_ENABLE: cfg_in.escape_enable = csr_data[0];
            sfe_pkg::CSR_FLAG_BYTE:     cfg_in.flag_byte     = csr_data;
            sfe_pkg::CSR_ESCAPE_PREFIX: cfg_in.escape_prefix = csr_data;
            sfe_pkg::CSR_PREFIX_CODE:   cfg_in.prefix_code   = csr_data;
            sfe_pkg::CSR_FLAG_CODE:     cfg_in.flag_code     = csr_data;
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.escape_enable <= sfe_pkg::RST_ESCAPE_ENABLE;
         cfg_ff.flag_byte     <= sfe_pkg::RST_FLAG_BYTE;
         cfg_ff.escape_prefix <= sfe_pkg::RST_ESCAPE_PREFIX;
         cfg_ff.prefix_code   <= sfe_pkg::RST_PREFIX_CODE;
         cfg_ff.flag_code     <= sfe_pkg::RST_FLAG_CODE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front end
   sfe_front #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .payload_byte  (req_tdata[7:0]),
      .first_byte    (req_tuser),
      .last_byte     (req_tlast),
      .command       (req_tdata[15:8]),
      .payload_count (req_tdata[31:16]),
      .q_ready       (q_ready),
      .push          (push),
      .job           (push_job)
   );

   // queue between the two ends
   sfe_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .q_ready    (q_ready),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head)
   );

   // back end
   sfe_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

FILE: dv/testbench.sv
// self-checking testbench for the stuffed frame encoder: queued stimulus, bus driver,
// receiver with stalls and a byte-level predictor checked against every output transfer
// depends on sfe_pkg and the stuffed_frame_encoder top level
`timescale 1ns / 1ps

module testbench;

   typedef struct {
      logic [7:0]  data;
      logic        first;
      logic        last;
      logic [7:0]  command;
      logic [15:0] count;
   } payload_item_type;

   typedef struct {
      logic [7:0] value;
      logic       frame_end;
   } line_byte_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic [31:0]                   req_tdata = '0;   // payload_byte, command, payload_count
   logic                          req_tuser = 1'b0; // first_byte
   logic                          req_tlast = 1'b0; // last_byte
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   logic [7:0]                    rsp_tdata;        // out_byte
   logic                          rsp_tlast;        // frame_end
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [sfe_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [7:0]                    csr_data = '0;

   // stimulus waiting for the driver and line bytes waiting for the monitor
   payload_item_type payload_queue[$];
   line_byte_type    frame_bytes_due[$];

   // predictor state
   sfe_pkg::cfg_type line_cfg;
   logic [7:0]       line_sum;
   logic             frame_open;

   int queued_items = 0;
   int accepted_items = 0;
   int mismatches = 0;
   int burst_left = 1;
   int gap_left = 0;
   int hold_left = 0;
   bit long_hold_done = 1'b0;
   int rx_mode = 0;
   int mode_left = 0;
   int rx_tick = 0;

   stuffed_frame_encoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #2 clock = ~clock;

   // predictor: line bytes caused by one payload byte
   function automatic void expect_line(logic [7:0] value, logic frame_end);
      frame_bytes_due.push_back('{value, frame_end});
   endfunction

   // prefix rule is tested first so it wins when prefix and flag coincide
   function automatic void expect_stuffed(logic [7:0] b);
      if (line_cfg.escape_enable && b == line_cfg.escape_prefix) begin
         expect_line(line_cfg.escape_prefix, 1'b0);
         expect_line(line_cfg.prefix_code, 1'b0);
      end else if (line_cfg.escape_enable && b == line_cfg.flag_byte) begin
         expect_line(line_cfg.escape_prefix, 1'b0);
         expect_line(line_cfg.flag_code, 1'b0);
      end else begin
         expect_line(b, 1'b0);
      end
   endfunction

   function automatic void encode_payload_byte(payload_item_type it);
      logic [31:0] len;
      if (it.first) begin
         // count is 16 bits wide, so it never exceeds the payload limit
         len = 32'(it.count) + 32'(sfe_pkg::HEADER_EXTRA);
         line_sum = 8'h00;
         expect_line(line_cfg.flag_byte, 1'b0);
         for (int k = 3; k >= 0; k--) begin
            line_sum = line_sum + len[8*k +: 8];
            expect_line(len[8*k +: 8], 1'b0);
         end
         line_sum = line_sum + it.command;
         expect_line(it.command, 1'b0);
         frame_open = 1'b1;
      end else if (!frame_open) begin
         return;
      end
      line_sum = line_sum + it.data;
      expect_stuffed(it.data);
      if (it.last) begin
         expect_stuffed(line_sum);
         expect_line(line_cfg.flag_byte, 1'b1);
         line_sum = 8'h00;
         frame_open = 1'b0;
      end
   endfunction

   // stimulus helpers
   function automatic logic [7:0] header_sum(logic [15:0] count, logic [7:0] command);
      logic [31:0] len;
      logic [7:0]  s;
      len = 32'(count) + 32'(sfe_pkg::HEADER_EXTRA);
      s = len[31:24] + len[23:16] + len[15:8] + len[7:0] + command;
      return s;
   endfunction

   function automatic logic [7:0] pick_payload_byte();
      case ($urandom_range(0, 7))
         0: return line_cfg.flag_byte;
         1: return line_cfg.escape_prefix;
         2: return line_cfg.prefix_code;
         3: return line_cfg.flag_code;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic queue_item(input logic [7:0] data, input logic first, input logic last,
                             input logic [7:0] command, input logic [15:0] count);
      payload_queue.push_back('{data, first, last, command, count});
      queued_items++;
   endtask

   // command and count are random on the bytes after the first, where they are unused
   task automatic queue_frame(input int nbytes, input logic [15:0] count, input bit closed);
      logic [7:0] command;
      command = 8'($urandom_range(0, 255));
      for (int i = 0; i < nbytes; i++) begin
         queue_item(pick_payload_byte(), i == 0, closed && i == nbytes - 1,
                    (i == 0) ? command : 8'($urandom_range(0, 255)),
                    (i == 0) ? count : 16'($urandom_range(0, 65535)));
      end
   endtask

   // mostly well-formed frames, some stray bytes and frames cut short by a new start
   task automatic queue_random_phase(input int frames);
      int          kind;
      int          nbytes;
      logic [15:0] count;
      for (int i = 0; i < frames; i++) begin
         kind = $urandom_range(0, 9);
         nbytes = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 6);
         case ($urandom_range(0, 5))
            0: count = 16'($urandom_range(0, 65535));
            1: count = ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000;
            default: count = 16'(nbytes);
         endcase
         if (kind == 0) begin
            queue_item(pick_payload_byte(), 1'b0, 1'($urandom_range(0, 1)),
                       8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
         end else begin
            queue_frame(nbytes, count, kind != 1);
         end
      end
      // leave no frame open across a register change
      nbytes = $urandom_range(1, 4);
      queue_frame(nbytes, 16'(nbytes), 1'b1);
   endtask

   // sender pause: wait for every item and every line byte, then the tail latency
   task automatic wait_drained();
      while (accepted_items != queued_items || frame_bytes_due.size() != 0)
         @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic write_reg(input logic [sfe_pkg::CSR_IDX_W-1:0] index,
                            input logic [7:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // an idle wait at the end so the predictor holds the new settings
   task automatic set_config(input logic escape_enable, input logic [7:0] flag_byte,
                             input logic [7:0] escape_prefix, input logic [7:0] prefix_code,
                             input logic [7:0] flag_code);
      write_reg(sfe_pkg::CSR_ESCAPE_ENABLE, {7'd0, escape_enable});
      write_reg(sfe_pkg::CSR_FLAG_BYTE, flag_byte);
      write_reg(sfe_pkg::CSR_ESCAPE_PREFIX, escape_prefix);
      write_reg(sfe_pkg::CSR_PREFIX_CODE, prefix_code);
      write_reg(sfe_pkg::CSR_FLAG_CODE, flag_code);
      @(posedge clock);
   endtask

   // payload driver: bursts of random length with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            void'(payload_queue.pop_front());
            if (burst_left > 0) burst_left--;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 16);
               gap_left = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : 0;
            end
         end
         // an offered item stays on the bus until its transfer
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (payload_queue.size() > 0) begin
               req_tvalid <= 1'b1;
               req_tdata <= {payload_queue[0].count, payload_queue[0].command,
                             payload_queue[0].data};
               req_tuser <= payload_queue[0].first;
               req_tlast <= payload_queue[0].last;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // receiver: changing stall patterns plus one long hold-off to back up the input
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rx_tick++;
         if (!long_hold_done && accepted_items >= 10 && payload_queue.size() > 8) begin
            long_hold_done = 1'b1;
            hold_left = 300;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               rx_mode = $urandom_range(0, 3);
               mode_left = $urandom_range(16, 96);
            end else begin
               mode_left--;
            end
            case (rx_mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= 1'($urandom_range(0, 1));
               2: rsp_tready <= ($urandom_range(0, 3) != 0);
               default: rsp_tready <= ((rx_tick % 5) < 2);
            endcase
         end
      end
   end

   // monitor: register writes, payload transfers into the predictor, line byte checks
   always @(posedge clock) begin
      if (reset) begin
         line_cfg = '{sfe_pkg::RST_ESCAPE_ENABLE, sfe_pkg::RST_FLAG_BYTE,
                      sfe_pkg::RST_ESCAPE_PREFIX, sfe_pkg::RST_PREFIX_CODE,
                      sfe_pkg::RST_FLAG_CODE};
         line_sum = 8'h00;
         frame_open = 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               sfe_pkg::CSR_ESCAPE_ENABLE: line_cfg.escape_enable = csr_data[0];
               sfe_pkg::CSR_FLAG_BYTE:     line_cfg.flag_byte = csr_data;
               sfe_pkg::CSR_ESCAPE_PREFIX: line_cfg.escape_prefix = csr_data;
               sfe_pkg::CSR_PREFIX_CODE:   line_cfg.prefix_code = csr_data;
               sfe_pkg::CSR_FLAG_CODE:     line_cfg.flag_code = csr_data;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            encode_payload_byte('{req_tdata[7:0], req_tuser, req_tlast,
                                  req_tdata[15:8], req_tdata[31:16]});
            accepted_items++;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (frame_bytes_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected output byte %h frame_end %b", rsp_tdata, rsp_tlast);
            end else begin
               line_byte_type due;
               due = frame_bytes_due.pop_front();
               if (rsp_tdata !== due.value || rsp_tlast !== due.frame_end) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("output mismatch: expected byte %h frame_end %b, got %h %b",
                              due.value, due.frame_end, rsp_tdata, rsp_tlast);
               end
            end
         end
      end
   end

   // stimulus sequence
   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed part under reset settings
      queue_item(8'h5A, 1'b0, 1'b0, 8'h11, 16'd3);       // byte with no frame open
      queue_item(8'h00, 1'b1, 1'b1, 8'h00, 16'd1);       // first and last together
      queue_item(8'hFF, 1'b1, 1'b0, 8'hFF, 16'hFFFF);    // largest count
      queue_item(sfe_pkg::RST_FLAG_BYTE, 1'b0, 1'b0, 8'h00, 16'h0000);
      queue_item(sfe_pkg::RST_ESCAPE_PREFIX, 1'b0, 1'b0, 8'h00, 16'h0000);
      queue_item(sfe_pkg::RST_FLAG_CODE, 1'b0, 1'b0, 8'hFF, 16'hFFFF);
      queue_item(sfe_pkg::RST_PREFIX_CODE, 1'b0, 1'b0, 8'h00, 16'h0000);
      queue_item(8'h55, 1'b0, 1'b1, 8'hFF, 16'hFFFF);
      // last with no frame open
      queue_item(sfe_pkg::RST_FLAG_BYTE, 1'b0, 1'b1, 8'h22, 16'd9);
      queue_item(8'h12, 1'b1, 1'b0, 8'h80, 16'd3);
      queue_item(sfe_pkg::RST_ESCAPE_PREFIX, 1'b0, 1'b0, 8'h00, 16'd0);
      queue_item(8'h34, 1'b1, 1'b0, 8'h01, 16'd2);       // restart abandons open frame
      queue_item(sfe_pkg::RST_FLAG_BYTE, 1'b0, 1'b1, 8'h00, 16'd0);
      queue_item(8'h77, 1'b1, 1'b1, 8'h5C, 16'd0);       // zero count
      // checksum landing on the flag, then on the prefix
      queue_item(sfe_pkg::RST_FLAG_BYTE - header_sum(16'd1, 8'h33), 1'b1, 1'b1,
                 8'h33, 16'd1);
      queue_item(sfe_pkg::RST_ESCAPE_PREFIX - header_sum(16'd1, 8'h33), 1'b1, 1'b1,
                 8'h33, 16'd1);
      queue_item(8'hC3, 1'b1, 1'b1, 8'h7E, 16'h0100);
      queue_random_phase(5);
      wait_drained();

      // escaping off
      set_config(1'b0, sfe_pkg::RST_FLAG_BYTE, sfe_pkg::RST_ESCAPE_PREFIX,
                 sfe_pkg::RST_PREFIX_CODE, sfe_pkg::RST_FLAG_CODE);
      queue_random_phase(5);
      wait_drained();

      // extreme values
      set_config(1'b1, 8'h00, 8'hFF, 8'h00, 8'hFF);
      queue_random_phase(5);
      wait_drained();

      // prefix and flag equal, prefix rule wins
      set_config(1'b1, 8'h7E, 8'h7E, 8'h7D, 8'h5E);
      queue_random_phase(5);
      wait_drained();

      // random settings
      set_config(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)));
      queue_random_phase(5);
      wait_drained();

      // opposite extremes
      set_config(1'b1, 8'hFF, 8'h00, 8'hFF, 8'h00);
      queue_random_phase(5);
      wait_drained();

      if (mismatches == 0 && frame_bytes_due.size() == 0) begin
         $display("stuffed_frame_encoder test passed");
      end else begin
         $display("stuffed_frame_encoder test failed");
      end
      $finish;
   end

   // run limit
   initial begin
      #2000000;
      $display("stuffed_frame_encoder test failed");
      $finish;
   end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/sfe_pkg.sv
hw/rtl/sfe_front.sv
hw/rtl/sfe_queue.sv
hw/rtl/sfe_back.sv
hw/rtl/stuffed_frame_encoder.sv
dv/testbench.sv
